@@ hw/rtl/dtcm_pkg.sv @@
// Shared types and constants of the dual threshold crossing monitor.
package dtcm_pkg;

   localparam int DEFAULT_CHANNELS = 4;

   localparam int CHAN_W  = 2;
   localparam int TEMP_W  = 16;
   localparam int CSR_W   = 32;
   localparam int IDX_W   = 2;
   localparam int REACT_W = 8;
   localparam int CODE_W  = 7;
   localparam int TH1_W   = 17;

   localparam int REACT_REG_W = 32;
   localparam int CODES_REG_W = 28;

   localparam logic [IDX_W-1:0] REG_REACTION = 2'd0;
   localparam logic [IDX_W-1:0] REG_T1_CODES = 2'd1;
   localparam logic [IDX_W-1:0] REG_T2_LEVEL = 2'd2;

   localparam int T1_BASE = -5500;
   localparam int T1_STEP = 180;

   localparam logic [REACT_W-1:0] RISE2_MASK = 8'h0C;
   localparam logic [REACT_W-1:0] RISE1_MASK = 8'hC0;
   localparam logic [REACT_W-1:0] FALL1_MASK = 8'h30;
   localparam logic [REACT_W-1:0] FALL2_MASK = 8'h03;

   localparam int RISE2_LSB = 2;
   localparam int RISE1_LSB = 6;
   localparam int FALL1_LSB = 4;
   localparam int FALL2_LSB = 0;

   typedef struct packed {
      logic changed;
      logic value;
   } verdict_type;

   typedef struct packed {
      logic                     enable;
      logic [CHAN_W-1:0]        channel;
      logic signed [TEMP_W-1:0] temperature;
      logic                     limit_write;
      logic                     limit_value;
   } state_update_type;

endpackage

@@ hw/rtl/dtcm_eval.sv @@
// Crossing evaluation for one sample against both thresholds.
module dtcm_eval (
   input  logic [dtcm_pkg::REACT_W-1:0]       react,
   input  logic [dtcm_pkg::CODE_W-1:0]        code,
   input  logic signed [dtcm_pkg::TEMP_W-1:0] level_two,
   input  logic signed [dtcm_pkg::TEMP_W-1:0] prev_temp,
   input  logic signed [dtcm_pkg::TEMP_W-1:0] temperature,
   input  logic                               restart,
   output dtcm_pkg::verdict_type              verdict
);

   localparam int TW = dtcm_pkg::TH1_W;

   logic signed [TW-1:0] th1;
   logic signed [TW-1:0] th2;
   logic signed [TW-1:0] prev_x;
   logic signed [TW-1:0] temp_x;
   logic                 rise2_hit;
   logic                 rise1_hit;
   logic                 fall1_hit;
   logic                 fall2_hit;

   assign th1 = signed'(TW'(dtcm_pkg::T1_BASE)
                        + TW'(dtcm_pkg::T1_STEP) * TW'(code));
   assign th2    = TW'(level_two);
   assign prev_x = TW'(prev_temp);
   assign temp_x = TW'(temperature);

   assign rise2_hit = (prev_x < th2 || restart) && temp_x > th2
                      && ((react & dtcm_pkg::RISE2_MASK) != '0);
   assign rise1_hit = (prev_x < th1 || restart) && temp_x > th1
                      && ((react & dtcm_pkg::RISE1_MASK) != '0);
   assign fall1_hit = (prev_x > th1 || restart) && temp_x < th1
                      && ((react & dtcm_pkg::FALL1_MASK) != '0);
   assign fall2_hit = (prev_x > th2 || restart) && temp_x < th2
                      && ((react & dtcm_pkg::FALL2_MASK) != '0);

   // when several crossings match, fall2 wins, then fall1, rise1 and rise2
   always_comb begin
      verdict.changed = rise2_hit || rise1_hit || fall1_hit || fall2_hit;
      verdict.value   = 1'b0;
      if (fall2_hit) begin
         verdict.value = react[dtcm_pkg::FALL2_LSB];
      end else if (fall1_hit) begin
         verdict.value = react[dtcm_pkg::FALL1_LSB];
      end else if (rise1_hit) begin
         verdict.value = react[dtcm_pkg::RISE1_LSB];
      end else if (rise2_hit) begin
         verdict.value = react[dtcm_pkg::RISE2_LSB];
      end
   end

endmodule

@@ hw/rtl/dtcm_state.sv @@
// Per-channel previous sample and limit bit registers.
module dtcm_state #(
   parameter int CHANNELS = dtcm_pkg::DEFAULT_CHANNELS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [dtcm_pkg::CHAN_W-1:0]        rd_channel,
   input  dtcm_pkg::state_update_type         update,
   output logic signed [dtcm_pkg::TEMP_W-1:0] rd_prev,
   output logic                               rd_limit
);

   logic signed [dtcm_pkg::TEMP_W-1:0] prev_ff [CHANNELS];
   logic signed [dtcm_pkg::TEMP_W-1:0] prev_in [CHANNELS];
   logic                               limit_ff [CHANNELS];
   logic                               limit_in [CHANNELS];

   always_comb begin
      rd_prev  = '0;
      rd_limit = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (int'(rd_channel) == c) begin
            rd_prev  = prev_ff[c];
            rd_limit = limit_ff[c];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         prev_in[c]  = prev_ff[c];
         limit_in[c] = limit_ff[c];
         if (update.enable && int'(update.channel) == c) begin
            prev_in[c] = update.temperature;
            if (update.limit_write) begin
               limit_in[c] = update.limit_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (reset) begin
            prev_ff[c]  <= '0;
            limit_ff[c] <= 1'b0;
         end else begin
            prev_ff[c]  <= prev_in[c];
            limit_ff[c] <= limit_in[c];
         end
      end
   end

endmodule

@@ hw/rtl/dual_threshold_crossing_monitor_unit.sv @@
// Top level of the dual threshold crossing monitor.
//
// Each sample transfer on the req_ channel yields exactly one rsp_ transfer, in order.
// A sample is captured in an input register; there the channel state is read, both
// thresholds are compared and the channel state and the result register are written
// together once the result register can advance. rsp_valid rises once the sample has
// passed the input and result registers. Unless rsp_ stalls, one sample is taken every
// clock, as the per-channel state is read and written in the same cycle. Samples for
// the same channel may follow each other back to back. Configuration is written through
// csr_ at any time the block holds no sample; writes to an index above 2 are dropped.
module dual_threshold_crossing_monitor_unit #(
   parameter int CHANNELS = dtcm_pkg::DEFAULT_CHANNELS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dtcm_pkg::CHAN_W-1:0]        req_channel,
   input  logic signed [dtcm_pkg::TEMP_W-1:0] req_temperature,
   input  logic                               req_restart_pending,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dtcm_pkg::CHAN_W-1:0]        rsp_result_channel,
   output logic                               rsp_limit_state,
   output logic                               rsp_limit_changed,
   output logic                               rsp_send_report,
   input  logic                               csr_write_enable,
   input  logic [dtcm_pkg::IDX_W-1:0]         csr_index,
   input  logic [dtcm_pkg::CSR_W-1:0]         csr_write_data
);

   localparam int SEL_W = 5;

   logic [dtcm_pkg::REACT_REG_W-1:0]   reaction_ff;
   logic [dtcm_pkg::CODES_REG_W-1:0]   codes_ff;
   logic signed [dtcm_pkg::TEMP_W-1:0] level_two_ff;

   logic                               s1_valid_ff;
   logic                               s1_valid_in;
   logic [dtcm_pkg::CHAN_W-1:0]        s1_channel_ff;
   logic signed [dtcm_pkg::TEMP_W-1:0] s1_temp_ff;
   logic                               s1_restart_ff;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [dtcm_pkg::CHAN_W-1:0]        rsp_channel_ff;
   logic                               rsp_limit_ff;
   logic                               rsp_limit_in;
   logic                               rsp_changed_ff;
   logic                               rsp_changed_in;
   logic                               rsp_report_ff;
   logic                               rsp_report_in;

   logic                               advance;
   logic                               accept;
   logic                               present;
   logic [dtcm_pkg::REACT_W-1:0]       react;
   logic [dtcm_pkg::CODE_W-1:0]        code;
   logic signed [dtcm_pkg::TEMP_W-1:0] prev_temp;
   logic                               old_limit;
   dtcm_pkg::verdict_type              verdict;
   dtcm_pkg::state_update_type         update;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reaction_ff  <= '0;
         codes_ff     <= '0;
         level_two_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            dtcm_pkg::REG_REACTION: begin
               reaction_ff <= csr_write_data[dtcm_pkg::REACT_REG_W-1:0];
            end
            dtcm_pkg::REG_T1_CODES: begin
               codes_ff <= csr_write_data[dtcm_pkg::CODES_REG_W-1:0];
            end
            dtcm_pkg::REG_T2_LEVEL: begin
               level_two_ff <= signed'(csr_write_data[dtcm_pkg::TEMP_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // flow control
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_channel_ff <= req_channel;
         s1_temp_ff    <= req_temperature;
         s1_restart_ff <= req_restart_pending;
      end
   end

   // evaluation
   assign present = int'(s1_channel_ff) < CHANNELS;
   assign react   = dtcm_pkg::REACT_W'(reaction_ff >> (SEL_W'(s1_channel_ff)
                                                      * SEL_W'(dtcm_pkg::REACT_W)));
   assign code    = dtcm_pkg::CODE_W'(codes_ff >> (SEL_W'(s1_channel_ff)
                                                  * SEL_W'(dtcm_pkg::CODE_W)));

   dtcm_state #(
      .CHANNELS(CHANNELS)
   ) u_state (
      .clock      (clock),
      .reset      (reset),
      .rd_channel (s1_channel_ff),
      .update     (update),
      .rd_prev    (prev_temp),
      .rd_limit   (old_limit)
   );

   dtcm_eval u_eval (
      .react       (react),
      .code        (code),
      .level_two   (level_two_ff),
      .prev_temp   (prev_temp),
      .temperature (s1_temp_ff),
      .restart     (s1_restart_ff),
      .verdict     (verdict)
   );

   always_comb begin
      update.enable      = advance && s1_valid_ff && present;
      update.channel     = s1_channel_ff;
      update.temperature = s1_temp_ff;
      update.limit_write = verdict.changed;
      update.limit_value = verdict.value;
   end

   assign rsp_changed_in = present && verdict.changed;
   assign rsp_limit_in   = present && (verdict.changed ? verdict.value : old_limit);
   assign rsp_report_in  = rsp_changed_in && !s1_restart_ff;

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_channel_ff <= s1_channel_ff;
         rsp_limit_ff   <= rsp_limit_in;
         rsp_changed_ff <= rsp_changed_in;
         rsp_report_ff  <= rsp_report_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_channel = rsp_channel_ff;
   assign rsp_limit_state    = rsp_limit_ff;
   assign rsp_limit_changed  = rsp_changed_ff;
   assign rsp_send_report    = rsp_report_ff;

endmodule

@@ hw/rtl/dtcm_checker.sv @@
// Port-level checks of the dual threshold crossing monitor, bound to its top level.
module dtcm_checker #(
   parameter int CHANNELS = dtcm_pkg::DEFAULT_CHANNELS
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [dtcm_pkg::CHAN_W-1:0]        rsp_result_channel,
   input logic                               rsp_limit_state,
   input logic                               rsp_limit_changed,
   input logic                               rsp_send_report
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_channel)
         && $stable(rsp_limit_state) && $stable(rsp_limit_changed)
         && $stable(rsp_send_report))
      else $error("result changed while stalled");

   a_report_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_report |-> rsp_limit_changed)
      else $error("report flagged without a limit change");

   a_absent_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && int'(rsp_result_channel) >= CHANNELS
         |-> !rsp_limit_state && !rsp_limit_changed)
      else $error("absent channel produced a limit value");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result side can move");

endmodule

bind dual_threshold_crossing_monitor_unit dtcm_checker #(
   .CHANNELS(CHANNELS)
) u_dtcm_checker (.*);
